// ===== sv/assert_macros.svh =====
// Shared assertion macros; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define SPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication check: when cond holds, prop holds.
`define SPQ_ASSERT_IMPL(name, cond, prop, msg) \
  `SPQ_ASSERT(name, (cond) |-> (prop), msg)

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned CapacityDef     = 16;
  localparam int unsigned PriorityBitsDef = 16;
  localparam int unsigned PayloadBitsDef  = 32;

  // Request codes carried on the one-bit req_type field.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Per-cycle shift command broadcast to every cell.
  typedef struct packed {
    logic push;  // insert new entry in order
    logic pop;   // shift everything one cell toward the head
  } spq_ctrl_t;

endpackage

// ===== sv/spq_if.sv =====
interface spq_in_if #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned PAYLOAD_BITS  = 32
);
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [PRIORITY_BITS-1:0] in_priority;
  logic [PAYLOAD_BITS-1:0]  in_payload;

  modport source (output valid, req_type, in_priority, in_payload, input ready);
  modport sink   (input valid, req_type, in_priority, in_payload, output ready);
endinterface

interface spq_out_if #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned PAYLOAD_BITS  = 32
);
  logic                     valid;
  logic                     ready;
  logic                     pop_valid;
  logic [PRIORITY_BITS-1:0] out_priority;
  logic [PAYLOAD_BITS-1:0]  out_payload;
  logic                     push_dropped;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, pop_valid, out_priority, out_payload, push_dropped,
                  is_empty, is_full, input ready);
  modport sink   (input valid, pop_valid, out_priority, out_payload, push_dropped,
                  is_empty, is_full, output ready);
endinterface

// ===== sv/spq_cell.sv =====
module spq_cell #(
  parameter int unsigned PRIORITY_BITS = 16,
  parameter int unsigned PAYLOAD_BITS  = 32
) (
  input  logic                      clk_i,
  input  spq_pkg::spq_ctrl_t        ctrl_i,
  input  logic                      occ_i,        // this cell holds an entry
  input  logic [PRIORITY_BITS-1:0]  new_pri_i,
  input  logic [PAYLOAD_BITS-1:0]   new_pay_i,
  input  logic                      prev_stay_i,  // left neighbor keeps its entry
  input  logic [PRIORITY_BITS-1:0]  prev_pri_i,
  input  logic [PAYLOAD_BITS-1:0]   prev_pay_i,
  input  logic [PRIORITY_BITS-1:0]  next_pri_i,
  input  logic [PAYLOAD_BITS-1:0]   next_pay_i,
  output logic                      stay_o,
  output logic [PRIORITY_BITS-1:0]  pri_o,
  output logic [PAYLOAD_BITS-1:0]   pay_o
);
  import spq_pkg::*;

  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;

  // Equal priority stays ahead, so ties leave in arrival order.
  assign stay_o = occ_i && (pri_q <= new_pri_i);

  always_comb begin
    pri_d = pri_q;
    pay_d = pay_q;
    if (ctrl_i.pop) begin
      pri_d = next_pri_i;
      pay_d = next_pay_i;
    end else if (ctrl_i.push && !stay_o) begin
      if (prev_stay_i) begin
        pri_d = new_pri_i;
        pay_d = new_pay_i;
      end else begin
        pri_d = prev_pri_i;
        pay_d = prev_pay_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    pay_q <= pay_d;
  end

  assign pri_o = pri_q;
  assign pay_o = pay_q;

endmodule

// ===== sv/stable_sorted_priority_queue.sv =====
// Channel   Dir   Fields
// in_i      sink  req_type, in_priority, in_payload
// out_o     src   pop_valid, out_priority, out_payload, push_dropped, is_empty, is_full
//
// One request per cycle unless out_o stalls: the push compare runs in every cell in parallel and
// the insert/shift finishes in the cell chain in the same edge.
// The result sits in an output register; in_i.ready is low only while it is
// held by a stalled out_o.
// Reset clears the entry count and the output valid flag; cell contents are left as they are.
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY      = spq_pkg::CapacityDef,
  parameter int unsigned PRIORITY_BITS = spq_pkg::PriorityBitsDef,
  parameter int unsigned PAYLOAD_BITS  = spq_pkg::PayloadBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);
  import spq_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            fire;
  logic            is_push, is_pop, full, empty;
  spq_ctrl_t       ctrl;

  logic [CAPACITY-1:0]      stay;
  logic [PRIORITY_BITS-1:0] pri   [CAPACITY];
  logic [PAYLOAD_BITS-1:0]  pay   [CAPACITY];

  logic                     out_valid_q;
  logic                     pop_valid_q, pop_valid_d;
  logic [PRIORITY_BITS-1:0] out_pri_q, out_pri_d;
  logic [PAYLOAD_BITS-1:0]  out_pay_q, out_pay_d;
  logic                     dropped_q, dropped_d;
  logic                     empty_q, full_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign is_push    = fire && (in_i.req_type == REQ_PUSH);
  assign is_pop     = fire && (in_i.req_type == REQ_POP);

  assign ctrl.push = is_push && !full;
  assign ctrl.pop  = is_pop && !empty;

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_stay;
    logic [PRIORITY_BITS-1:0] prev_pri, next_pri;
    logic [PAYLOAD_BITS-1:0]  prev_pay, next_pay;

    if (i == 0) begin : g_head
      assign prev_stay = 1'b1;
      assign prev_pri  = in_i.in_priority;
      assign prev_pay  = in_i.in_payload;
    end else begin : g_body
      assign prev_stay = stay[i-1];
      assign prev_pri  = pri[i-1];
      assign prev_pay  = pay[i-1];
    end

    // Tail cell becomes unoccupied on a pop; its data does not matter.
    if (i == CAPACITY - 1) begin : g_tail
      assign next_pri = pri[i];
      assign next_pay = pay[i];
    end else begin : g_inner
      assign next_pri = pri[i+1];
      assign next_pay = pay[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (count_q > CntW'(i)),
      .new_pri_i  (in_i.in_priority),
      .new_pay_i  (in_i.in_payload),
      .prev_stay_i(prev_stay),
      .prev_pri_i (prev_pri),
      .prev_pay_i (prev_pay),
      .next_pri_i (next_pri),
      .next_pay_i (next_pay),
      .stay_o     (stay[i]),
      .pri_o      (pri[i]),
      .pay_o      (pay[i])
    );
  end

  always_comb begin
    pop_valid_d = ctrl.pop;
    out_pri_d   = ctrl.pop ? pri[0] : '0;
    out_pay_d   = ctrl.pop ? pay[0] : '0;
    dropped_d   = is_push && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pop_valid_q <= pop_valid_d;
      out_pri_q   <= out_pri_d;
      out_pay_q   <= out_pay_d;
      dropped_q   <= dropped_d;
      empty_q     <= (count_d == '0);
      full_q      <= (count_d == CntW'(CAPACITY));
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pop_valid    = pop_valid_q;
  assign out_o.out_priority = out_pri_q;
  assign out_o.out_payload  = out_pay_q;
  assign out_o.push_dropped = dropped_q;
  assign out_o.is_empty     = empty_q;
  assign out_o.is_full      = full_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(CAPACITY), "entry count exceeds capacity")
  `SPQ_ASSERT_IMPL(a_pop_head, ctrl.pop, ##1 (out_o.valid && out_o.pop_valid && out_o.out_priority == $past(pri[0])), "pop did not return head cell")
  `SPQ_ASSERT_IMPL(a_drop_full, is_push && full, ##1 (out_o.push_dropped && out_o.is_full), "push into full queue not flagged")
  `SPQ_ASSERT_IMPL(a_stall_hold, out_valid_q && !out_o.ready, ##1 $stable(count_q), "queue changed while result stalled")

endmodule
